// ----- rtl/bipartite_max_matching_defines.svh -----
// ----------------------------------------------------------------------------
// bipartite_max_matching_defines
// assertion macros for the checker of the matching block
// ----------------------------------------------------------------------------
`ifndef BIPARTITE_MAX_MATCHING_DEFINES_SVH
`define BIPARTITE_MAX_MATCHING_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define BMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define BMM_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg
// shared types and codes of the bipartite matching block
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam logic [0:0] REG_TASK_COUNT  = 1'b0;
  localparam logic [0:0] REG_STAFF_COUNT = 1'b1;

  localparam logic MODE_EDGE   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [6:0] COUNT_RESET = 7'd64;

  typedef struct packed {
    logic start;
  } search_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } search_sts_t;

endpackage

// ----- rtl/bmm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bmm_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_search
// augmenting-path engine: one breadth-first search per free task, with
// queue, parent and partner tables held in rams
// ----------------------------------------------------------------------------
module bmm_search #(
  parameter int MAX_TASKS = 64,
  parameter int MAX_STAFF = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bmm_pkg::search_ctl_t             ctl,
  input  logic [$clog2(MAX_TASKS+1)-1:0]   nt,
  input  logic [$clog2(MAX_STAFF+1)-1:0]   ns,
  output logic [$clog2(MAX_TASKS)-1:0]     edge_raddr,
  input  logic [MAX_STAFF-1:0]             edge_rdata,
  output bmm_pkg::search_sts_t             sts,
  output logic [$clog2(MAX_TASKS+1)-1:0]   count
);

  localparam int TW  = $clog2(MAX_TASKS);
  localparam int SW  = $clog2(MAX_STAFF);
  localparam int CTW = $clog2(MAX_TASKS+1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ROOT = 10'b0000000010,
    S_POP  = 10'b0000000100,
    S_POPW = 10'b0000001000,
    S_ROW  = 10'b0000010000,
    S_SCAN = 10'b0000100000,
    S_OWN  = 10'b0001000000,
    S_AUG0 = 10'b0010000000,
    S_AUG1 = 10'b0100000000,
    S_AUG2 = 10'b1000000000
  } state_t;

  state_t state;
  logic [CTW-1:0]       root;
  logic [CTW-1:0]       qhead;
  logic [CTW-1:0]       qtail;
  logic [TW-1:0]        u;
  logic [TW-1:0]        w;
  logic [SW-1:0]        v;
  logic [MAX_STAFF-1:0] row;
  logic [MAX_STAFF-1:0] smask;
  logic [MAX_STAFF-1:0] visited;
  logic [MAX_STAFF-1:0] smatch;
  logic [MAX_TASKS-1:0] seen;
  logic [MAX_TASKS-1:0] tmatch;

  logic [MAX_STAFF-1:0] cand;
  logic [MAX_STAFF-1:0] smask_next;
  logic [SW-1:0]        s_low;
  logic                 has_cand;

  logic          q_we;
  logic [TW-1:0] q_waddr;
  logic [TW-1:0] q_wdata;
  logic [TW-1:0] q_rdata;
  logic [TW-1:0] par_rdata;
  logic [TW-1:0] sp_rdata;
  logic [SW-1:0] tp_rdata;

  assign cand     = row & ~visited;
  assign has_cand = |cand;

  always_comb begin
    s_low = '0;
    for (int i = MAX_STAFF - 1; i >= 0; i--) begin
      if (cand[i]) begin
        s_low = SW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STAFF; i++) begin
      smask_next[i] = (32'(i) < 32'(ns));
    end
  end

  always_comb begin
    q_we    = 1'b0;
    q_waddr = qtail[TW-1:0];
    q_wdata = sp_rdata;
    if (state == S_ROOT && root != nt) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = root[TW-1:0];
    end else if (state == S_OWN && !seen[sp_rdata]) begin
      q_we = 1'b1;
    end
  end

  assign edge_raddr = q_rdata;
  assign sts.busy   = (state != S_IDLE);
  assign sts.done   = (state == S_ROOT) && (root == nt);

  bmm_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(qhead[TW-1:0]), .rdata(q_rdata)
  );

  // parent of each staff member reached in the current search
  bmm_ram #(.WIDTH(TW), .DEPTH(MAX_STAFF)) u_parent (
    .clk(clk), .we(state == S_SCAN && has_cand), .waddr(s_low), .wdata(u),
    .raddr(v), .rdata(par_rdata)
  );

  bmm_ram #(.WIDTH(TW), .DEPTH(MAX_STAFF)) u_staff_partner (
    .clk(clk), .we(state == S_AUG2), .waddr(v), .wdata(w),
    .raddr(s_low), .rdata(sp_rdata)
  );

  bmm_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_task_partner (
    .clk(clk), .we(state == S_AUG2), .waddr(w), .wdata(v),
    .raddr(par_rdata), .rdata(tp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            smatch <= '0;
            tmatch <= '0;
            count  <= '0;
            root   <= '0;
            smask  <= smask_next;
            state  <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root == nt) begin
            state <= S_IDLE;
          end else begin
            visited <= '0;
            seen    <= {{(MAX_TASKS-1){1'b0}}, 1'b1} << root[TW-1:0];
            qhead   <= '0;
            qtail   <= CTW'(1);
            state   <= S_POP;
          end
        end
        S_POP: begin
          if (qhead == qtail) begin
            root  <= root + CTW'(1);
            state <= S_ROOT;
          end else begin
            qhead <= qhead + CTW'(1);
            state <= S_POPW;
          end
        end
        S_POPW: begin
          u     <= q_rdata;
          state <= S_ROW;
        end
        S_ROW: begin
          row   <= edge_rdata & smask;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!has_cand) begin
            state <= S_POP;
          end else begin
            visited[s_low] <= 1'b1;
            v <= s_low;
            if (!smatch[s_low]) begin
              state <= S_AUG0;
            end else begin
              state <= S_OWN;
            end
          end
        end
        S_OWN: begin
          if (!seen[sp_rdata]) begin
            seen[sp_rdata] <= 1'b1;
            qtail <= qtail + CTW'(1);
          end
          state <= S_SCAN;
        end
        S_AUG0: begin
          state <= S_AUG1;
        end
        S_AUG1: begin
          w     <= par_rdata;
          state <= S_AUG2;
        end
        S_AUG2: begin
          smatch[v] <= 1'b1;
          if (!tmatch[w]) begin
            // reached the free root task, path applied
            tmatch[w] <= 1'b1;
            count <= count + CTW'(1);
            root  <= root + CTW'(1);
            state <= S_ROOT;
          end else begin
            v     <= tp_rdata;
            state <= S_AUG0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bipartite_max_matching.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bipartite_max_matching
// maximum matching of tasks to staff over a loaded adjacency matrix
// ----------------------------------------------------------------------------
// Input items arrive on item_valid / item_stall. A mode 0 item adds one edge
// (task_index, staff_index) to the edge ram; edges are taken one per cycle
// while item_stall is low, with forwarding between back-to-back writes to
// the same row. An edge outside the configured counts is dropped and flagged.
// A mode 1 item starts the search engine: one breadth-first search per task,
// which pops tasks from a queue, scans the staff of each popped task and
// applies the augmenting path it finds, if any, step by step. The result
// (matching_size, edge_dropped) is then held on result_valid until a transfer
// with result_stall low. A stalled result does not hold up edge items, only
// the next finish item.
// After each finish, and after reset, the edge ram is cleared one row per
// cycle, all MAX_TASKS rows, with item_stall high. task_count and staff_count
// are written through cfg_write_en / cfg_index / cfg_data and reset to 64.
// ----------------------------------------------------------------------------
module bipartite_max_matching #(
  parameter int MAX_TASKS = 64,
  parameter int MAX_STAFF = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       mode,
  input  logic [5:0] task_index,
  input  logic [5:0] staff_index,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [6:0] matching_size,
  output logic       edge_dropped
);

  localparam int TW  = $clog2(MAX_TASKS);
  localparam int CTW = $clog2(MAX_TASKS+1);
  localparam int CSW = $clog2(MAX_STAFF+1);

  typedef enum logic [2:0] {
    T_CLEAR = 3'b001,
    T_LOAD  = 3'b010,
    T_BUSY  = 3'b100
  } state_t;

  state_t state;
  logic [6:0]           task_count;
  logic [6:0]           staff_count;
  logic [TW-1:0]        clr_addr;
  logic                 s1_valid;
  logic [TW-1:0]        s1_addr;
  logic [MAX_STAFF-1:0] s1_mask;
  logic                 w_valid;
  logic [TW-1:0]        w_addr;
  logic [MAX_STAFF-1:0] w_data;
  logic                 drop;
  logic                 start;

  logic [CTW-1:0]       nt;
  logic [CSW-1:0]       ns;
  logic                 item_fire;
  logic                 in_range;
  logic                 e_we;
  logic [TW-1:0]        e_waddr;
  logic [MAX_STAFF-1:0] e_wdata;
  logic [TW-1:0]        e_raddr;
  logic [MAX_STAFF-1:0] e_rdata;
  logic [TW-1:0]        srch_raddr;
  logic [CTW-1:0]       srch_count;
  bmm_pkg::search_ctl_t srch_ctl;
  bmm_pkg::search_sts_t srch_sts;

  assign nt = (32'(task_count) > 32'(MAX_TASKS)) ? CTW'(MAX_TASKS) : CTW'(task_count);
  assign ns = (32'(staff_count) > 32'(MAX_STAFF)) ? CSW'(MAX_STAFF) : CSW'(staff_count);

  assign item_stall = (state != T_LOAD) || (result_valid && mode == bmm_pkg::MODE_FINISH);
  assign item_fire  = item_valid && !item_stall;
  assign in_range   = (32'(task_index) < 32'(nt)) && (32'(staff_index) < 32'(ns));

  assign e_raddr = (state == T_BUSY) ? srch_raddr : TW'(task_index);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = s1_addr;
    e_wdata = ((w_valid && w_addr == s1_addr) ? w_data : e_rdata) | s1_mask;
    if (state == T_CLEAR) begin
      e_we    = 1'b1;
      e_waddr = clr_addr;
      e_wdata = '0;
    end else if (s1_valid) begin
      e_we = 1'b1;
    end
  end

  assign srch_ctl.start = start;

  bmm_ram #(.WIDTH(MAX_STAFF), .DEPTH(MAX_TASKS)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  bmm_search #(.MAX_TASKS(MAX_TASKS), .MAX_STAFF(MAX_STAFF)) u_search (
    .clk(clk), .rst(rst), .ctl(srch_ctl), .nt(nt), .ns(ns),
    .edge_raddr(srch_raddr), .edge_rdata(e_rdata),
    .sts(srch_sts), .count(srch_count)
  );

  // payload of the row update, no reset needed
  always_ff @(posedge clk) begin
    s1_addr <= TW'(task_index);
    s1_mask <= {{(MAX_STAFF-1){1'b0}}, 1'b1} << staff_index;
    w_addr  <= e_waddr;
    w_data  <= e_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_CLEAR;
      task_count   <= bmm_pkg::COUNT_RESET;
      staff_count  <= bmm_pkg::COUNT_RESET;
      clr_addr     <= '0;
      s1_valid     <= 1'b0;
      w_valid      <= 1'b0;
      drop         <= 1'b0;
      start        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          bmm_pkg::REG_TASK_COUNT:  task_count  <= cfg_data;
          bmm_pkg::REG_STAFF_COUNT: staff_count <= cfg_data;
          default: ;
        endcase
      end
      s1_valid <= item_fire && mode == bmm_pkg::MODE_EDGE && in_range;
      w_valid  <= s1_valid && state != T_CLEAR;
      start    <= item_fire && mode == bmm_pkg::MODE_FINISH;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (item_fire && mode == bmm_pkg::MODE_EDGE && !in_range) begin
        drop <= 1'b1;
      end
      case (state)
        T_CLEAR: begin
          clr_addr <= clr_addr + TW'(1);
          if (clr_addr == TW'(MAX_TASKS - 1)) begin
            state <= T_LOAD;
          end
        end
        T_LOAD: begin
          if (item_fire && mode == bmm_pkg::MODE_FINISH) begin
            state <= T_BUSY;
          end
        end
        T_BUSY: begin
          if (srch_sts.done) begin
            result_valid  <= 1'b1;
            matching_size <= 7'(srch_count);
            edge_dropped  <= drop;
            drop          <= 1'b0;
            clr_addr      <= '0;
            state         <= T_CLEAR;
          end
        end
        default: begin
          state <= T_CLEAR;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bmm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_checker
// port-level checks of the matching block, bound to the top level
// ----------------------------------------------------------------------------
`include "bipartite_max_matching_defines.svh"

module bmm_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       mode,
  input logic       result_valid,
  input logic       result_stall,
  input logic [6:0] matching_size,
  input logic       edge_dropped
);

  `BMM_ASSERT_ALWAYS(a_reset_quiet, rst, !result_valid, "result shown right after reset")
  `BMM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(matching_size) && $stable(edge_dropped), "stalled result changed")
  `BMM_ASSERT_IMP(a_size_bound, result_valid, matching_size <= 7'd64, "matching size above bound")
  `BMM_ASSERT_NEXT(a_finish_gap, item_valid && !item_stall && mode, !result_valid, "result before search ran")

endmodule

bind bipartite_max_matching bmm_checker u_bmm_checker (
  .clk(clk),
  .rst(rst),
  .item_valid(item_valid),
  .item_stall(item_stall),
  .mode(mode),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .matching_size(matching_size),
  .edge_dropped(edge_dropped)
);
